### hw/rtl/dahb_pkg.sv
// dahb_pkg: shared constants, types and the arctangent table for the heading block.
// Used by every module under hw/rtl; has no dependencies of its own.
package dahb_pkg;
	localparam int CordicStagesDef = 24;
	localparam int AngleBitsDef = 32;
	localparam int SC_W = 33;               // sine/cosine, Q30 plus headroom
	localparam int XY_W = 36;               // atan2 datapath width
	localparam int HEAD_W = 25;
	localparam logic signed [SC_W-1:0] GainQ30 = 33'sd652032874;
	localparam logic [63:0] InvTwoPiQ64 = 64'h28BE60DB9391054A;

	// atan(2^-i) in angle units of an ab-bit turn, series in 64-bit turn units
	function automatic logic [63:0] atan_entry(input int i, input int ab);
		logic [63:0] t;
		logic [63:0] term;
		int k;
		if (i == 0) begin
			t = 64'd1 << 61;
		end else begin
			t = '0;
			for (k = 0; k < 32; k++) begin
				if (i * (2 * k + 1) < 64) begin
					term = (InvTwoPiQ64 >> (i * (2 * k + 1))) / 64'(2 * k + 1);
					if (k % 2 == 1) t = t - term;
					else t = t + term;
				end
			end
		end
		return (t + (64'd1 << (63 - ab))) >> (64 - ab);
	endfunction
endpackage

### hw/rtl/dahb_sincos.sv
// dahb_sincos: pipelined rotation-mode CORDIC, one stage per register.
// Depends on dahb_pkg.
module dahb_sincos import dahb_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef,
	parameter int ANGLE_BITS = AngleBitsDef
) (
	input  logic clk,
	input  logic en,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic signed [SC_W-1:0] cos_o,
	output logic signed [SC_W-1:0] sin_o
);
	localparam int ZW = ANGLE_BITS + 1;
	logic signed [SC_W-1:0] x_s [1:CORDIC_STAGES];
	logic signed [SC_W-1:0] y_s [1:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [1:CORDIC_STAGES];
	logic neg_s [1:CORDIC_STAGES];
	logic [1:0] quad;
	logic [ANGLE_BITS-1:0] a_fold;
	logic neg_in;

	assign quad = angle[ANGLE_BITS-1 -: 2];
	assign neg_in = (quad == 2'd1 || quad == 2'd2);
	assign a_fold = neg_in ? angle - {1'b1, {(ANGLE_BITS-1){1'b0}}} : angle;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
		localparam logic [ZW-1:0] Tab = ZW'(atan_entry(i, ANGLE_BITS));
		logic signed [SC_W-1:0] x_c;
		logic signed [SC_W-1:0] y_c;
		logic signed [ZW-1:0] z_c;
		logic neg_c;
		if (i == 0) begin : g_head
			assign x_c = GainQ30;
			assign y_c = '0;
			assign z_c = ZW'(signed'(a_fold));
			assign neg_c = neg_in;
		end else begin : g_body
			assign x_c = x_s[i];
			assign y_c = y_s[i];
			assign z_c = z_s[i];
			assign neg_c = neg_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_c[ZW-1]) begin
					x_s[i+1] <= x_c - (y_c >>> i);
					y_s[i+1] <= y_c + (x_c >>> i);
					z_s[i+1] <= z_c - signed'(Tab);
				end else begin
					x_s[i+1] <= x_c + (y_c >>> i);
					y_s[i+1] <= y_c - (x_c >>> i);
					z_s[i+1] <= z_c + signed'(Tab);
				end
				neg_s[i+1] <= neg_c;
			end
		end
	end

	assign cos_o = neg_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
	assign sin_o = neg_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];
endmodule

### hw/rtl/dahb_atan2.sv
// dahb_atan2: pipelined vectoring-mode CORDIC with quadrant fold and clamp.
// Depends on dahb_pkg.
module dahb_atan2 import dahb_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef,
	parameter int ANGLE_BITS = AngleBitsDef
) (
	input  logic clk,
	input  logic en,
	input  logic signed [XY_W-1:0] y_in,
	input  logic signed [XY_W-1:0] x_in,
	output logic signed [ANGLE_BITS+1:0] theta
);
	localparam int ZW = ANGLE_BITS + 2;
	localparam logic signed [ZW-1:0] Quarter = ZW'(1) <<< (ANGLE_BITS - 2);
	localparam logic signed [ZW-1:0] Half = ZW'(1) <<< (ANGLE_BITS - 1);
	logic signed [XY_W-1:0] x_s [1:CORDIC_STAGES];
	logic signed [XY_W-1:0] y_s [1:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [1:CORDIC_STAGES];
	logic zero_s [1:CORDIC_STAGES];
	logic signed [XY_W-1:0] x_f;
	logic signed [XY_W-1:0] y_f;
	logic signed [ZW-1:0] z_f;
	logic zero_f;

	// fold the left half plane onto the right one
	always_comb begin
		x_f = x_in;
		y_f = y_in;
		z_f = '0;
		zero_f = (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_f = y_in; y_f = -x_in; z_f = Quarter;
			end else begin
				x_f = -y_in; y_f = x_in; z_f = -Quarter;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
		localparam logic [ZW-1:0] Tab = ZW'(atan_entry(i, ANGLE_BITS));
		logic signed [XY_W-1:0] x_c;
		logic signed [XY_W-1:0] y_c;
		logic signed [ZW-1:0] z_c;
		logic zero_c;
		if (i == 0) begin : g_head
			assign x_c = x_f;
			assign y_c = y_f;
			assign z_c = z_f;
			assign zero_c = zero_f;
		end else begin : g_body
			assign x_c = x_s[i];
			assign y_c = y_s[i];
			assign z_c = z_s[i];
			assign zero_c = zero_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_c[XY_W-1]) begin
					x_s[i+1] <= x_c + (y_c >>> i);
					y_s[i+1] <= y_c - (x_c >>> i);
					z_s[i+1] <= z_c + signed'(Tab);
				end else begin
					x_s[i+1] <= x_c - (y_c >>> i);
					y_s[i+1] <= y_c + (x_c >>> i);
					z_s[i+1] <= z_c - signed'(Tab);
				end
				zero_s[i+1] <= zero_c;
			end
		end
	end

	always_comb begin
		if (zero_s[CORDIC_STAGES]) theta = '0;
		else if (z_s[CORDIC_STAGES] > Half) theta = Half;
		else if (z_s[CORDIC_STAGES] < -Half) theta = -Half;
		else theta = z_s[CORDIC_STAGES];
	end
endmodule

### hw/rtl/dual_antenna_heading_bearing.sv
// dual_antenna_heading_bearing: great-circle initial bearing main->aux, plus 180 deg.
// Stages in order: sin/cos CORDIC, product registers, atan2 CORDIC and conversion to
// degrees; one word per cycle unless stalled. Whole pipe advances when the output
// register is empty or taken (global stall), so nothing is lost or repeated.
// Reset (arst_n low, async) clears only the valid bits; payload is unreset.
// Depends on dahb_pkg, dahb_sincos, dahb_atan2.
module dual_antenna_heading_bearing import dahb_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef,
	parameter int ANGLE_BITS = AngleBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic signed [31:0] base_lat,
	input  logic signed [31:0] base_lon,
	input  logic signed [31:0] aux_lat,
	input  logic signed [31:0] aux_lon,
	output logic valid_out,
	input  logic ready_out,
	output logic [HEAD_W-1:0] heading_deg
);
	localparam int LAT = 2 * CORDIC_STAGES + 5;
	localparam int SH = ANGLE_BITS - 16;
	localparam int PW = 2 * SC_W;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [HEAD_W-1:0] head_q;

	// Pipe moves whenever the final register can take a new word.
	assign en = !valid_out || ready_out;
	assign ready_in = en;
	assign valid_out = vld_q[LAT-1];
	assign heading_deg = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], valid_in};
		end
	end

	// 32-bit input angle mapped onto an ANGLE_BITS turn
	function automatic logic [ANGLE_BITS-1:0] to_ang(input logic [31:0] v);
		logic [79:0] w;
		w = {48'd0, v} << 48;
		return w[79 -: ANGLE_BITS];
	endfunction

	logic [31:0] dlon;
	assign dlon = aux_lon - base_lon;

	logic signed [SC_W-1:0] c1, s1, c2, s2, cd, sd;
	dahb_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_sc1 (
		.clk, .en, .angle(to_ang(base_lat)), .cos_o(c1), .sin_o(s1));
	dahb_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_sc2 (
		.clk, .en, .angle(to_ang(aux_lat)), .cos_o(c2), .sin_o(s2));
	dahb_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_scd (
		.clk, .en, .angle(to_ang(dlon)), .cos_o(cd), .sin_o(sd));

	// Q30 x Q30 rounded half up
	function automatic logic signed [SC_W-1:0] rq30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + (PW'(1) <<< 29)) >>> 30;
		return t[SC_W-1:0];
	endfunction

	// product stages
	logic signed [SC_W-1:0] y_p1, a_p1, b_p1, cd_p1, y_p2, a_p2, b_p2;
	logic signed [XY_W-1:0] x_p3, y_p3;
	always_ff @(posedge clk) begin
		if (en) begin
			y_p1 <= rq30(PW'(sd) * PW'(c2));
			a_p1 <= rq30(PW'(c1) * PW'(s2));
			b_p1 <= rq30(PW'(s1) * PW'(c2));
			cd_p1 <= cd;
			y_p2 <= y_p1;
			a_p2 <= a_p1;
			b_p2 <= rq30(PW'(b_p1) * PW'(cd_p1));
			y_p3 <= XY_W'(y_p2);
			x_p3 <= XY_W'(a_p2) - XY_W'(b_p2);
		end
	end

	logic signed [ANGLE_BITS+1:0] theta;
	dahb_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_at (
		.clk, .en, .y_in(y_p3), .x_in(x_p3), .theta(theta));

	// degrees: (theta + half) * 360, rounded into 16 fraction bits
	logic [ANGLE_BITS+9:0] deg_s1;
	logic [ANGLE_BITS+9:0] rnd;
	always_comb begin
		rnd = '0;
		if (SH > 0) rnd = (ANGLE_BITS+10)'(1) << (SH - 1);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1 <= (ANGLE_BITS+10)'(theta + ((ANGLE_BITS+2)'(1) <<< (ANGLE_BITS-1)))
				* (ANGLE_BITS+10)'(360);
			head_q <= HEAD_W'((deg_s1 + rnd) >> SH);
		end
	end
endmodule

### dv/tb_dual_antenna_heading_bearing.sv
// Testbench for dual_antenna_heading_bearing: drives antenna fixes, predicts the
// CORDIC heading in integer arithmetic and checks each output word in order.
// Depends on dahb_pkg and the RTL top; reads no files.

class heading_scoreboard;
	logic [24:0] pending_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function void note_fix(logic [24:0] h);
		pending_q.push_back(h);
	endfunction

	function void check_heading(logic [24:0] got);
		logic [24:0] exp_h;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected heading word, expected none, actual %0d", $realtime, got);
			errors++;
		end else begin
			exp_h = pending_q.pop_front();
			if (exp_h !== got) begin
				$display("%0t: heading_deg mismatch, expected %0d, actual %0d",
					$realtime, exp_h, got);
				errors++;
			end
		end
	endfunction
endclass

module tb_dual_antenna_heading_bearing;
	import dahb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = CordicStagesDef;
	localparam int LAT_CYC = 2 * STAGES + 5;
	localparam longint HALF = 64'sd1 << 31;
	localparam longint FULL = 64'sd1 << 32;
	localparam longint QTR = 64'sd1 << 30;
	localparam longint LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic valid_in = 0;
	logic ready_out = 0;
	logic signed [31:0] base_lat = 0, base_lon = 0, aux_lat = 0, aux_lon = 0;
	logic ready_in, valid_out;
	logic [HEAD_W-1:0] heading_deg;

	// idle percentages per phase, plus a long hold-off request
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;
	longint cycles = 0;
	longint atan_tab[STAGES];
	heading_scoreboard sb;

	dual_antenna_heading_bearing u_dut (
		.clk, .arst_n, .valid_in, .ready_in, .base_lat, .base_lon, .aux_lat, .aux_lon,
		.valid_out, .ready_out, .heading_deg
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// floor shift for signed values
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	// arctangent table by alternating series in 64-bit turn units
	function automatic longint arctan_units(int i);
		logic [63:0] t, term;
		if (i == 0) begin
			t = 64'd1 << 61;
		end else begin
			t = 0;
			for (int k = 0; i * (2 * k + 1) < 64; k++) begin
				term = (64'h28BE60DB9391054A >> (i * (2 * k + 1))) / (2 * k + 1);
				if (k % 2) t -= term;
				else t += term;
			end
		end
		return longint'((t + (64'd1 << 31)) >> 32);
	endfunction

	task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, xs, ys, a;
		bit flip;
		a = ang;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip) a = (a - HALF) & (FULL - 1);
		z = (a >= HALF) ? a - FULL : a;
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_tab[i];
			end else begin
				x += ys; y -= xs; z += atan_tab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QTR;
			end else begin
				t = x; x = -y; y = t; z = -QTR;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_tab[i];
			end else begin
				x -= ys; y += xs; z -= atan_tab[i];
			end
		end
		if (z > HALF) z = HALF;
		if (z < -HALF) z = -HALF;
		return z;
	endfunction

	task automatic predict_heading(input logic [31:0] mlat, mlon, alat, alon,
			output logic [24:0] h);
		longint c1, s1, c2, s2, cd, sd, y, x, th;
		logic [63:0] d;
		sin_cos(mlat, c1, s1);
		sin_cos(alat, c2, s2);
		sin_cos(alon - mlon, cd, sd);
		y = q30_mul(sd, c2);
		x = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
		th = vector_angle(y, x);
		d = 64'(th + HALF) * 360;
		d = (d + (64'd1 << 15)) >> 16;
		h = d[24:0];
	endtask

	// one word; waits for acceptance, gaps taken at random before it
	task automatic send_fix(input logic [31:0] mlat, mlon, alat, alon);
		logic [24:0] h;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			valid_in <= 0;
			@(negedge clk);
		end
		base_lat <= mlat;
		base_lon <= mlon;
		aux_lat <= alat;
		aux_lon <= alon;
		valid_in <= 1;
		predict_heading(mlat, mlon, alat, alon, h);
		do @(posedge clk); while (!ready_in);
		sb.note_fix(h);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_lat();
		return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
	endfunction

	// receiver: stalls at random or holds off when asked
	always @(negedge clk) begin
		if (!arst_n) ready_out <= 0;
		else if (hold_off) ready_out <= 0;
		else ready_out <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && valid_out && ready_out) sb.check_heading(heading_deg);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic run_random(input int n);
		logic [31:0] ml, al, mo;
		for (int k = 0; k < n; k++) begin
			ml = rand_lat();
			mo = $urandom;
			case ($urandom_range(3))
				// antennas a short baseline apart, the usual use
				0, 1: send_fix(ml, mo, ml + $urandom_range(4000) - 2000,
					mo + $urandom_range(4000) - 2000);
				// identical positions (zero vector) one time in eight, else a random aux fix
				2: if ($urandom_range(7) == 0) send_fix(ml, mo, ml, mo);
					else send_fix(ml, mo, rand_lat(), $urandom);
				// raw 32-bit latitudes beyond the poles too
				default: send_fix($urandom, $urandom, $urandom, $urandom);
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < STAGES; i++) atan_tab[i] = arctan_units(i);
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: extremes, wraps, poles, zero vector
		send_fix(0, 0, 0, 0);
		send_fix(32'sh4000_0000, 0, 32'sh4000_0000, 0);
		send_fix(-32'sh4000_0000, 0, -32'sh4000_0000, 32'sh7FFF_FFFF);
		send_fix(0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
		send_fix(0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000);
		send_fix(0, 0, 100, 0);
		send_fix(0, 0, -100, 0);
		send_fix(0, 0, 0, 100);
		send_fix(0, 0, 0, -100);
		send_fix(0, 0, -100, -1);
		send_fix(0, 0, -100, 1);
		send_fix(32'sh4000_0000, 0, 0, 12345);
		send_fix(-32'sh4000_0000, 0, 0, 12345);
		send_fix(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0);
		send_fix(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
		send_fix(12345678, -9876543, 12345678, -9876543);

		send_idle = 0; recv_stall = 0; run_random(100);
		send_idle = 49; run_random(100);
		send_idle = 0; recv_stall = 49; run_random(100);
		send_idle = 9; recv_stall = 9; run_random(80);

		// long hold-off while the sender keeps offering, to fill the pipe
		send_idle = 0; recv_stall = 0;
		fork
			begin
				hold_off = 1;
				repeat (3 * LAT_CYC) @(negedge clk);
				hold_off = 0;
			end
			run_random(70);
		join
		valid_in <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LAT_CYC) @(posedge clk);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
